[src/hcbd_pkg.sv]
package hcbd_pkg;

  // Longest size line accepted, counting its CR LF
  localparam int MAX_LINE_BYTES = 65536;
  // Width of a chunk size
  localparam int SIZE_BITS = 32;
  localparam int LINE_LEN_BITS = $clog2(MAX_LINE_BYTES + 1);
  localparam int DIGIT_CNT_BITS = 4;

  // Queue between the front and back parts
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  localparam logic [2:0] KIND_CONTENT = 3'd0;
  localparam logic [2:0] KIND_COMPLETE = 3'd1;
  localparam logic [2:0] KIND_PARTIAL = 3'd2;
  localparam logic [2:0] KIND_LONG = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW = 3'd4;

  // Character codes
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_VT = 8'h0b;
  localparam logic [7:0] CHAR_FF = 8'h0c;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       chunk_last;
  } out_item_t;

  // Classified beat handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       is_hex;
    logic [3:0] digit;
    logic       is_blank;
    logic       is_cr;
    logic       is_lf;
  } beat_t;

endpackage

[src/hcbd_front.sv]
module hcbd_front (
  input  hcbd_pkg::in_item_t in_item,
  output hcbd_pkg::beat_t    beat
);

  logic [7:0] b;

  assign b = in_item.in_byte;

  // Classify the byte for the line parser
  always_comb begin
    beat = '0;
    beat.data = b;
    beat.eos = in_item.end_of_stream;
    beat.is_cr = (b == hcbd_pkg::CHAR_CR);
    beat.is_lf = (b == hcbd_pkg::CHAR_LF);
    beat.is_blank = (b == hcbd_pkg::CHAR_SPACE) || (b == hcbd_pkg::CHAR_TAB) ||
                    (b == hcbd_pkg::CHAR_LF) || (b == hcbd_pkg::CHAR_VT) ||
                    (b == hcbd_pkg::CHAR_FF) || (b == hcbd_pkg::CHAR_CR);
    if (b >= 8'h30 && b <= 8'h39) begin
      beat.is_hex = 1'b1;
      beat.digit = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      beat.is_hex = 1'b1;
      beat.digit = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      beat.is_hex = 1'b1;
      beat.digit = 4'(b - 8'h37);
    end
  end

endmodule

[src/hcbd_fifo.sv]
module hcbd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hcbd_pkg::beat_t push_beat,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hcbd_pkg::beat_t head
);

  hcbd_pkg::beat_t                      slots [hcbd_pkg::FIFO_DEPTH];
  logic [hcbd_pkg::FIFO_PTR_BITS-1:0]   wr_ptr;
  logic [hcbd_pkg::FIFO_PTR_BITS-1:0]   rd_ptr;
  logic [hcbd_pkg::FIFO_CNT_BITS-1:0]   count;
  logic                                 do_push;
  logic                                 do_pop;

  assign full = (count == hcbd_pkg::FIFO_CNT_BITS'(hcbd_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == hcbd_pkg::FIFO_PTR_BITS'(hcbd_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == hcbd_pkg::FIFO_PTR_BITS'(hcbd_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

endmodule

[src/hcbd_back.sv]
module hcbd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat_valid,
  input  hcbd_pkg::beat_t     beat,
  output logic                beat_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbd_pkg::out_item_t out_item
);

  localparam logic [2:0] PH_LINE = 3'd0;
  localparam logic [2:0] PH_DATA = 3'd1;
  localparam logic [2:0] PH_TRAIL = 3'd2;
  localparam logic [2:0] PH_FINAL = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  logic [2:0]                          phase, phase_next;
  logic [hcbd_pkg::SIZE_BITS-1:0]      bytes_left, bytes_left_next;
  logic [hcbd_pkg::SIZE_BITS-1:0]      size_value, size_value_next;
  logic [hcbd_pkg::DIGIT_CNT_BITS-1:0] digit_count, digit_count_next;
  logic                                digits_done, digits_done_next;
  logic                                saw_cr, saw_cr_next;
  logic [hcbd_pkg::LINE_LEN_BITS-1:0]  line_length, line_length_next;
  logic [hcbd_pkg::LINE_LEN_BITS-1:0]  len_inc;
  logic                                few_left;
  logic                                emit;
  hcbd_pkg::out_item_t                 result;

  // Take a beat whenever the output register can hold its result
  assign beat_pop = beat_valid && (!out_valid || out_ready);
  assign len_inc = line_length + 1'b1;
  assign few_left = (bytes_left <= hcbd_pkg::SIZE_BITS'(1));

  // Decode one beat
  always_comb begin
    phase_next = phase;
    bytes_left_next = bytes_left;
    size_value_next = size_value;
    digit_count_next = digit_count;
    digits_done_next = digits_done;
    saw_cr_next = saw_cr;
    line_length_next = line_length;
    emit = 1'b0;
    result = '0;
    if (phase == PH_DONE || phase == PH_STOP) begin
      emit = 1'b0;
    end else if (beat.eos) begin
      phase_next = PH_STOP;
      emit = 1'b1;
      result.kind = hcbd_pkg::KIND_PARTIAL;
    end else begin
      unique case (phase)
        PH_LINE: begin
          if (saw_cr && beat.is_lf) begin
            size_value_next = '0;
            digit_count_next = '0;
            digits_done_next = 1'b0;
            saw_cr_next = 1'b0;
            line_length_next = '0;
            if (size_value == '0) begin
              phase_next = PH_FINAL;
              bytes_left_next = hcbd_pkg::SIZE_BITS'(2);
            end else begin
              phase_next = PH_DATA;
              bytes_left_next = size_value;
            end
          end else begin
            saw_cr_next = beat.is_cr;
            line_length_next = len_inc;
            if (!digits_done && beat.is_hex &&
                size_value[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
              phase_next = PH_STOP;
              emit = 1'b1;
              result.kind = hcbd_pkg::KIND_OVERFLOW;
            end else begin
              if (!digits_done) begin
                if (beat.is_hex) begin
                  size_value_next = {size_value[hcbd_pkg::SIZE_BITS-5:0], beat.digit};
                  if (digit_count != '1) begin
                    digit_count_next = digit_count + 1'b1;
                  end
                end else if (digit_count != '0 || !beat.is_blank) begin
                  digits_done_next = 1'b1;
                end
              end
              if (len_inc >= hcbd_pkg::LINE_LEN_BITS'(hcbd_pkg::MAX_LINE_BYTES)) begin
                phase_next = PH_STOP;
                emit = 1'b1;
                result.kind = hcbd_pkg::KIND_LONG;
              end
            end
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          result.out_byte = beat.data;
          result.kind = hcbd_pkg::KIND_CONTENT;
          result.chunk_last = few_left;
          if (few_left) begin
            phase_next = PH_TRAIL;
            bytes_left_next = hcbd_pkg::SIZE_BITS'(2);
          end else begin
            bytes_left_next = bytes_left - 1'b1;
          end
        end
        PH_TRAIL: begin
          if (few_left) begin
            bytes_left_next = '0;
            phase_next = PH_LINE;
            size_value_next = '0;
            digit_count_next = '0;
            digits_done_next = 1'b0;
            saw_cr_next = 1'b0;
            line_length_next = '0;
          end else begin
            bytes_left_next = bytes_left - 1'b1;
          end
        end
        PH_FINAL: begin
          if (few_left) begin
            bytes_left_next = '0;
            phase_next = PH_DONE;
            emit = 1'b1;
            result.kind = hcbd_pkg::KIND_COMPLETE;
          end else begin
            bytes_left_next = bytes_left - 1'b1;
          end
        end
        default: begin
          phase_next = PH_STOP;
        end
      endcase
    end
  end

  // Advance decoder state on each taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LINE;
      bytes_left <= '0;
      size_value <= '0;
      digit_count <= '0;
      digits_done <= 1'b0;
      saw_cr <= 1'b0;
      line_length <= '0;
    end else if (beat_pop) begin
      phase <= phase_next;
      bytes_left <= bytes_left_next;
      size_value <= size_value_next;
      digit_count <= digit_count_next;
      digits_done <= digits_done_next;
      saw_cr <= saw_cr_next;
      line_length <= line_length_next;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_pop && emit) begin
      out_item <= result;
    end
  end

endmodule

[src/http_chunked_body_decoder_unit.sv]
// Decodes an HTTP chunked body one byte per beat and sustains one input beat per
// clock while the output side keeps taking results. The front classifies each byte
// (hex digit, blank, CR, LF, end of stream) and writes it into a two-entry queue; the
// back runs the size-line/data/trailer state machine on the queue head and places at
// most one result per byte in an output register, so with the queue empty each
// result passes through a queue slot and then the output register. Content bytes
// come out with kind 0 and chunk_last on each chunk's final byte; kind 1 reports the
// end of the body, kinds 2 to 4 report early end of stream, an over-long size line
// and a size too wide for 32 bits. After completion or any error all further beats
// are taken and dropped until reset.
module http_chunked_body_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcbd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbd_pkg::out_item_t out_item
);

  hcbd_pkg::beat_t front_beat;
  hcbd_pkg::beat_t head_beat;
  logic            fifo_full;
  logic            fifo_not_empty;
  logic            beat_pop;

  assign in_ready = !fifo_full;

  // Classify incoming bytes
  hcbd_front u_front (
    .in_item (in_item),
    .beat    (front_beat)
  );

  // Queue classified beats
  hcbd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_beat (front_beat),
    .full      (fifo_full),
    .pop       (beat_pop),
    .not_empty (fifo_not_empty),
    .head      (head_beat)
  );

  // Decode and emit results
  hcbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (fifo_not_empty),
    .beat       (head_beat),
    .beat_pop   (beat_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
